[hdl/itac_pkg.sv]
package itac_pkg;

  // Width of the operand field on the input channel
  localparam int unsigned VALUE_BITS = 64;

  // Conversion modes carried in func
  localparam logic [1:0] FUNC_UDEC = 2'd0;
  localparam logic [1:0] FUNC_SDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;

  // Character constants
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_ALPHA_OFS = 8'd55;
  localparam logic [7:0] CH_MINUS     = 8'd45;
  localparam logic [7:0] CH_NINE      = 8'd57;
  localparam logic [7:0] CH_UPPER_A   = 8'd65;
  localparam logic [7:0] CH_UPPER_F   = 8'd70;

  // Entries in the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;       // magnitude (decimal) or raw value (hex)
    logic                  is_hex;
    logic                  neg;
    logic [1:0]            hex_size;
  } itac_cmd_t;

endpackage

[hdl/itac_if.sv]
interface itac_in_if;
  logic                             valid;
  logic                             ready;
  logic [itac_pkg::VALUE_BITS-1:0] value_bits;
  logic [1:0]                       func;
  logic [1:0]                       hex_size;

  modport source (output valid, value_bits, func, hex_size, input ready);
  modport sink   (input valid, value_bits, func, hex_size, output ready);
endinterface

interface itac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

[hdl/itac_front.sv]
module itac_front #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  itac_in_if.sink              in_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output itac_pkg::itac_cmd_t  cmd_o
);

  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   is_neg;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign val    = in_i.value_bits[VALUE_WIDTH-1:0];
  assign is_neg = (in_i.func == itac_pkg::FUNC_SDEC) && val[VALUE_WIDTH-1];
  // Two's complement magnitude; the most negative value wraps to its unsigned form
  assign mag    = is_neg ? (~val + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mag      = itac_pkg::VALUE_BITS'(mag);
    cmd_o.is_hex   = (in_i.func & itac_pkg::FUNC_HEX) != 2'd0;
    cmd_o.neg      = is_neg;
    cmd_o.hex_size = in_i.hex_size;
  end

endmodule

[hdl/itac_queue.sv]
module itac_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itac_pkg::itac_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output itac_pkg::itac_cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(itac_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(itac_pkg::QUEUE_DEPTH + 1);

  itac_pkg::itac_cmd_t mem_q [itac_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = count_q == CntW'(itac_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == itac_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == itac_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/itac_back.sv]
module itac_back #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  itac_pkg::itac_cmd_t cmd_i,
  output logic                pop_o,
  itac_out_if.source          out_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_DIGITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_HEX  = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [itac_pkg::VALUE_BITS-1:0] val_q;
  logic [3:0]                      bcd_q [MAX_DIGITS];
  logic [3:0]                      bcd_step [MAX_DIGITS];
  logic [MAX_DIGITS:0]             carry;
  logic [IdxW-1:0]                 idx_q;
  logic [CntW-1:0]                 cnt_q;
  logic                            neg_q;
  logic [7:0]                      char_q, char_d;
  logic                            last_q, last_d;
  logic                            out_valid_q;
  logic                            can_load;
  logic                            load_out;
  logic [3:0]                      sel_digit;
  logic [itac_pkg::VALUE_BITS-1:0] hex_shift;
  logic [3:0]                      nib;
  logic [4:0]                      hex_nibs;
  logic [IdxW-1:0]                 hex_idx;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n > 4'd9) ? ({4'd0, n} + itac_pkg::CH_ALPHA_OFS)
                          : ({4'd0, n} + itac_pkg::CH_ZERO);
  endfunction

  assign sel_digit = bcd_q[idx_q];
  assign hex_shift = val_q >> {idx_q, 2'b00};
  assign nib       = hex_shift[3:0];
  assign can_load  = !out_valid_q || out_o.ready;

  // First nibble to print: the top one, clipped to the last MAX_DIGITS characters
  assign hex_nibs = 5'd2 << cmd_i.hex_size;
  assign hex_idx  = (32'(hex_nibs) >= MAX_DIGITS) ? LastIdx : IdxW'(hex_nibs - 5'd1);

  // One double-dabble step: add 3 to digits of 5 or more, then shift in the next bit
  always_comb begin
    logic [3:0] adj;
    carry[0] = val_q[VALUE_WIDTH-1];
    for (int d = 0; d < MAX_DIGITS; d++) begin
      adj           = (bcd_q[d] >= 4'd5) ? bcd_q[d] + 4'd3 : bcd_q[d];
      bcd_step[d]   = {adj[2:0], carry[d]};
      carry[d+1]    = adj[3];
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    char_d   = itac_pkg::CH_ZERO;
    last_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = cmd_i.is_hex ? S_HEX : S_CONV;
        end
      end
      S_CONV: begin
        if (cnt_q == '0) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (idx_q == '0 || sel_digit != 4'd0) begin
          // Drop the sign when the digits alone fill the text
          state_d = (neg_q && idx_q != LastIdx) ? S_SIGN : S_DEC;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          load_out = 1'b1;
          char_d   = itac_pkg::CH_MINUS;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (can_load) begin
          load_out = 1'b1;
          char_d   = {4'd0, sel_digit} + itac_pkg::CH_ZERO;
          last_d   = idx_q == '0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      S_HEX: begin
        if (can_load) begin
          load_out = 1'b1;
          char_d   = hex_char(nib);
          last_d   = idx_q == '0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          val_q <= cmd_i.mag;
          neg_q <= cmd_i.neg;
          cnt_q <= CntW'(VALUE_WIDTH - 1);
          idx_q <= cmd_i.is_hex ? hex_idx : LastIdx;
          for (int d = 0; d < MAX_DIGITS; d++) begin
            bcd_q[d] <= 4'd0;
          end
        end
      end
      S_CONV: begin
        bcd_q <= bcd_step;
        val_q <= val_q << 1;
        cnt_q <= cnt_q - 1'b1;
      end
      S_TRIM: begin
        if (idx_q != '0 && sel_digit == 4'd0) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      S_DEC, S_HEX: begin
        if (load_out && idx_q != '0) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

endmodule

[hdl/integer_to_ascii_converter_unit.sv]
// Integer to ASCII converter. Each input beat carries a value and a mode (unsigned decimal,
// signed decimal or hex of 1, 2, 4 or 8 bytes); the block returns the text one character per
// output beat, last_char set on the final one, with no terminator. A front stage classifies
// the beat and takes the sign apart into a two-entry command queue, so new beats are taken
// while the back end works, until the queue is full. The back end converts decimal by double
// dabble, one bit per cycle, then skips leading zeros one digit per cycle, then sends one
// character per cycle while the output does not stall; hex is sent straight from the nibbles.
// The back end pops the next command only once the last character of the current one is
// loaded. The double-dabble loop sets the rate of decimal items.
module integer_to_ascii_converter_unit #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itac_in_if.sink     in_i,
  itac_out_if.source  out_o
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  itac_pkg::itac_cmd_t cmd_in;
  itac_pkg::itac_cmd_t cmd_out;

  itac_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (cmd_in)
  );

  itac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  itac_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (cmd_out),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

[hdl/itac_checker.sv]
module itac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] char_code_i,
  input logic       last_char_i
);

  // A stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(char_code_i) && $stable(last_char_i))
    else $error("output payload changed while stalled");

  // Only digits, uppercase hex letters and the minus sign appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (char_code_i >= itac_pkg::CH_ZERO && char_code_i <= itac_pkg::CH_NINE) ||
      (char_code_i >= itac_pkg::CH_UPPER_A && char_code_i <= itac_pkg::CH_UPPER_F) ||
      (char_code_i == itac_pkg::CH_MINUS))
    else $error("illegal character code");

  // A sign always has digits after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_code_i == itac_pkg::CH_MINUS |-> !last_char_i)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_converter_unit itac_checker u_itac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.char_code),
  .last_char_i (out_o.last_char)
);
